>>> rtl/core/prad_pkg.sv
// Package: shared types and constants for the priority range address decoder.
`timescale 1ns / 1ps

package prad_pkg;

  // Table geometry
  localparam int TABLE_DEPTH  = 8;
  localparam int DEVICE_COUNT = 16;
  localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);

  // Request opcodes
  typedef enum logic [2:0] {
    OP_MAP      = 3'd0,
    OP_RD_BYTE  = 3'd1,
    OP_RD_WORD  = 3'd2,
    OP_WR_BYTE  = 3'd3,
    OP_WR_WORD  = 3'd4
  } opcode_t;

  // Access kinds on the result side
  localparam logic [1:0] KIND_RD_BYTE = 2'd0;
  localparam logic [1:0] KIND_RD_WORD = 2'd1;
  localparam logic [1:0] KIND_WR_BYTE = 2'd2;
  localparam logic [1:0] KIND_WR_WORD = 2'd3;

  // One stored range
  typedef struct packed {
    logic [15:0] range_start;
    logic [15:0] range_end;
    logic [3:0]  device;
    logic        remap;
  } entry_t;

  // Lookup token walking down the cell chain
  typedef struct packed {
    logic        valid;
    logic        found;
    logic [15:0] address;
    logic [3:0]  device;
    logic [15:0] device_address;
  } token_t;

endpackage

>>> rtl/core/prad_cell.sv
// Cell: one table entry plus one stage of the lookup chain.
`timescale 1ns / 1ps

module prad_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift_en,
  input  logic            active,
  input  prad_pkg::entry_t entry_in,
  output prad_pkg::entry_t entry_out,
  input  prad_pkg::token_t tok_in,
  output prad_pkg::token_t tok_out
);
  import prad_pkg::*;

  entry_t entry;
  token_t tok;
  logic   match;

  // Entry storage, shifted toward older cells on a map request
  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry <= entry_in;
    end
  end

  // First match wins: older cells only look if nobody upstream matched
  assign match = active && !tok_in.found &&
                 (tok_in.address >= entry.range_start) &&
                 (tok_in.address <= entry.range_end);

  // Token stage: valid is control and is reset, the rest is payload
  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else begin
      tok.valid <= tok_in.valid;
    end
    tok.address <= tok_in.address;
    if (match) begin
      tok.found          <= 1'b1;
      tok.device         <= entry.device;
      tok.device_address <= entry.remap ? (tok_in.address - entry.range_start)
                                        : tok_in.address;
    end else begin
      tok.found          <= tok_in.found;
      tok.device         <= tok_in.device;
      tok.device_address <= tok_in.device_address;
    end
  end

  assign entry_out = entry;
  assign tok_out   = tok;

endmodule

>>> rtl/core/priority_range_address_decoder.sv
// Top level: priority range address decoder built as a chain of table cells.
// Lookup: a request's token is registered in each cell in turn; the result comes from the last cell.
// A new request is not accepted until the token of the previous lookup has reached the last cell.
// Map requests produce no result; busy is low for them.
// Synchronous active-high reset empties the table and clears the chain; no sweep.
// The receiver cannot stall: done marks each result for exactly one cycle.
`timescale 1ns / 1ps

module priority_range_address_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [15:0] address,
  input  logic [15:0] range_start,
  input  logic [15:0] range_end,
  input  logic [3:0]  target_device,
  input  logic        remap_flag,
  input  logic [15:0] write_data,
  output logic        done,
  output logic        hit,
  output logic [3:0]  selected_device,
  output logic [15:0] device_address,
  output logic [1:0]  access_kind,
  output logic [15:0] data_out
);
  import prad_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [1:0]       kind;
  logic [15:0]      dout;
  logic [1:0]       kind_next;
  logic [15:0]      dout_next;
  logic             accept;
  logic             is_access;
  logic             do_map;
  entry_t           new_entry;
  token_t           launch;
  entry_t           ent [TABLE_DEPTH];
  token_t           tok [TABLE_DEPTH];

  assign accept = start && !busy;

  // Decode the request
  always_comb begin
    is_access = 1'b1;
    kind_next = KIND_RD_BYTE;
    dout_next = 16'h0000;
    case (opcode_t'(opcode))
      OP_RD_BYTE: kind_next = KIND_RD_BYTE;
      OP_RD_WORD: kind_next = KIND_RD_WORD;
      OP_WR_BYTE: begin
        kind_next = KIND_WR_BYTE;
        dout_next = {8'h00, write_data[7:0]};
      end
      OP_WR_WORD: begin
        kind_next = KIND_WR_WORD;
        dout_next = write_data;
      end
      default: is_access = 1'b0;
    endcase
  end

  assign do_map = accept && (opcode_t'(opcode) == OP_MAP) &&
                  (32'(target_device) < DEVICE_COUNT);

  assign new_entry = '{range_start: range_start, range_end: range_end,
                       device: target_device, remap: remap_flag};

  assign launch = '{valid: accept && is_access, found: 1'b0, address: address,
                    device: 4'h0, device_address: 16'h0000};

  // Entry count saturates at the table depth
  always_comb begin
    count_next = count;
    if (do_map && (32'(count) < TABLE_DEPTH)) begin
      count_next = count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Access kind and write data held for the result
  always_ff @(posedge clk) begin
    if (accept && is_access) begin
      kind <= kind_next;
      dout <= dout_next;
    end
  end

  // Cell chain, newest entry at cell 0
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    prad_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift_en (do_map),
      .active   (32'(count) > i),
      .entry_in ((i == 0) ? new_entry : ent[(i == 0) ? 0 : i - 1]),
      .entry_out(ent[i]),
      .tok_in   ((i == 0) ? launch : tok[(i == 0) ? 0 : i - 1]),
      .tok_out  (tok[i])
    );
  end

  // Busy while the token is still short of the last cell
  always_comb begin
    busy = 1'b0;
    for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
      busy = busy | tok[i].valid;
    end
  end

  // Result from the last cell
  assign done            = tok[TABLE_DEPTH-1].valid;
  assign hit             = tok[TABLE_DEPTH-1].found;
  assign selected_device = tok[TABLE_DEPTH-1].device;
  assign device_address  = tok[TABLE_DEPTH-1].device_address;
  assign access_kind     = kind;
  assign data_out        = dout;

endmodule
